@@ hw/rtl/emgcf_pkg.sv @@
// shared types and constants for the emg comb filter envelope block
`default_nettype none
package emgcf_pkg;

	// right shift that turns the window sum into the envelope level
	localparam int LEVEL_SHIFT = 7;

	// pipeline control from the comb stage to the window stage
	typedef struct packed {
		logic advance;
		logic valid;
	} emgcf_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/emgcf_tap_cell.sv @@
// one cell of the comb delay line: holds one sample difference
`default_nettype none
module emgcf_tap_cell #(
	parameter int DIFF_W = 11
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     shift_en,
	input  wire logic signed [DIFF_W-1:0] d_in,
	output logic signed [DIFF_W-1:0]      d_out
);

	logic signed [DIFF_W-1:0] diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
		end else if (shift_en) begin
			diff_q <= d_in;
		end
	end

	assign d_out = diff_q;

endmodule
`default_nettype wire

@@ hw/rtl/emgcf_window_acc.sv @@
// rectify, window accumulate and level hold stage with output register
`default_nettype none
module emgcf_window_acc #(
	parameter int SAMPLE_BITS   = 10,
	parameter int WINDOW_LENGTH = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire emgcf_pkg::emgcf_ctl_t        ctl,
	input  wire logic signed [SAMPLE_BITS:0]  comb_sum,
	output logic                              out_valid,
	output logic [SAMPLE_BITS-1:0]            envelope_level,
	output logic                              window_done
);
	import emgcf_pkg::*;

	localparam int ACC_W = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
	localparam int CNT_W = $clog2(WINDOW_LENGTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LENGTH - 1);
	localparam logic [ACC_W-1:0] LEVEL_MAX = ACC_W'((1 << SAMPLE_BITS) - 1);

	logic [ACC_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] level_q;
	logic                   done_q;

	logic [SAMPLE_BITS:0]   neg_sum;
	logic [SAMPLE_BITS-1:0] mag;
	logic [ACC_W-1:0]       acc_next;
	logic [ACC_W-1:0]       lvl_wide;

	// magnitude never exceeds full scale since the sum telescopes
	always_comb begin
		neg_sum  = -comb_sum;
		mag      = comb_sum[SAMPLE_BITS] ? neg_sum[SAMPLE_BITS-1:0]
		                                 : comb_sum[SAMPLE_BITS-1:0];
		acc_next = acc_q + ACC_W'(mag);
		lvl_wide = acc_next >> LEVEL_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
			level_q <= '0;
			done_q  <= 1'b0;
		end else if (ctl.advance) begin
			valid_q <= ctl.valid;
			if (ctl.valid) begin
				if (cnt_q == CNT_LAST) begin
					acc_q   <= '0;
					cnt_q   <= '0;
					done_q  <= 1'b1;
					level_q <= (lvl_wide > LEVEL_MAX) ? LEVEL_MAX[SAMPLE_BITS-1:0]
					                                  : lvl_wide[SAMPLE_BITS-1:0];
				end else begin
					acc_q  <= acc_next;
					cnt_q  <= cnt_q + 1'b1;
					done_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid      = valid_q;
	assign envelope_level = level_q;
	assign window_done    = done_q;

endmodule
`default_nettype wire

@@ hw/rtl/emg_comb_filter_envelope_core.sv @@
// top level of the emg comb filter envelope block
// usage:
//   input channel: in_valid / in_stall with raw_sample, one adc sample per transfer
//   output channel: out_valid / out_stall with envelope_level and window_done,
//   exactly one result transfer per input transfer, in order
//   a result shows after its sample passes the comb and window stage registers
//   throughput: one sample per cycle while not stalled, set by the registered comb
//   update and the registered accumulate stage
//   the comb filter is a line of COMB_TAPS cells; each accepted sample shifts one
//   difference in at the head and one drops off the tail of the running sum
//   every WINDOW_LENGTH samples the accumulated magnitude, shifted right by 7 and
//   saturated at full scale, becomes the held level and window_done is set
//   reset (arst_n low): previous sample goes to mid-scale, cells, sums, window
//   count and held level clear, no result pending
//   when the receiver stalls a pending result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated
`default_nettype none
module emg_comb_filter_envelope_core #(
	parameter int COMB_TAPS     = 20,
	parameter int WINDOW_LENGTH = 128,
	parameter int SAMPLE_BITS   = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] raw_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [SAMPLE_BITS-1:0]      envelope_level,
	output logic                        window_done
);
	import emgcf_pkg::*;

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int WIDE_W = SAMPLE_BITS + 2;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

	// pipeline moves unless a finished result is waiting on a stalled receiver
	logic advance;
	logic accept;

	logic [SAMPLE_BITS-1:0]    prev_q;
	logic signed [DIFF_W-1:0]  comb_q;
	logic                      valid_s1;

	logic signed [DIFF_W-1:0]  diff;
	logic signed [WIDE_W-1:0]  comb_wide;
	logic signed [DIFF_W-1:0]  tap_w [COMB_TAPS+1];

	emgcf_ctl_t ctl;

	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	// difference against the previous sample, both zero extended
	always_comb begin
		diff      = $signed({1'b0, raw_sample}) - $signed({1'b0, prev_q});
		comb_wide = WIDE_W'(comb_q) - WIDE_W'(tap_w[COMB_TAPS]) + WIDE_W'(diff);
	end

	assign tap_w[0] = diff;

	// delay line of differences: head takes the new one, tail leaves the sum
	for (genvar i = 0; i < COMB_TAPS; i++) begin : g_tap
		emgcf_tap_cell #(
			.DIFF_W(DIFF_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(accept),
			.d_in    (tap_w[i]),
			.d_out   (tap_w[i+1])
		);
	end

	// comb stage: running sum always fits in DIFF_W bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= SAMPLE_MID;
			comb_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				prev_q <= raw_sample;
				comb_q <= comb_wide[DIFF_W-1:0];
			end
		end
	end

	assign ctl.advance = advance;
	assign ctl.valid   = valid_s1;

	emgcf_window_acc #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.comb_sum      (comb_q),
		.out_valid     (out_valid),
		.envelope_level(envelope_level),
		.window_done   (window_done)
	);

endmodule
`default_nettype wire
